[rtl/mhpq_pkg.sv]
// shared types and constants of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

   // heap geometry and field widths
   localparam int DEPTH     = 64;
   localparam int PRIO_BITS = 8;
   localparam int ID_BITS   = 16;
   localparam int KIND_BITS = 4;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int CHILD_W   = IDX_W + 2;
   localparam int ENTRY_W   = PRIO_BITS + ID_BITS + KIND_BITS;

   // stream data widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((ENTRY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;

   // one heap entry, priority in the lowest bits
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef enum logic {
      CMD_INSERT  = 1'b0,
      CMD_EXTRACT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_EXTRACTED = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SIFT_UP,
      S_LOAD,
      S_SIFT_DOWN,
      S_DONE
   } state_type;

   // one finished result
   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] count;
      entry_type        entry;
   } rsp_item_type;

endpackage

[rtl/mhpq_ram.sv]
// generic ram with one write port and two registered read ports
`timescale 1ns / 1ps

module mhpq_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 28
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [DATA_W-1:0] rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, both registered
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[rtl/mhpq_ctrl.sv]
// heap sequencer: insert sift-up, extract sift-down, over the entry ram
`timescale 1ns / 1ps

module mhpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  mhpq_pkg::cmd_type      in_cmd,
   input  mhpq_pkg::entry_type    in_entry,
   output logic                   out_valid,
   input  logic                   out_ready,
   output mhpq_pkg::rsp_item_type out_item
);
   import mhpq_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] hole_ff, hole_in;
   entry_type        item_ff, item_in;
   rsp_item_type     result_ff, result_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   entry_type        wr_data, rd_data_a, rd_data_b;

   logic             accept, full, empty;
   logic [IDX_W-1:0] new_idx, new_parent, hole_parent, hole_grand;
   logic             climb;
   logic [CHILD_W-1:0] l_idx, r_idx, count_wide;
   logic             take_l, take_r, descend;
   logic [PRIO_BITS-1:0] best_prio;
   logic [IDX_W-1:0] child_idx, child_l, child_r;
   entry_type        child_entry;

   mhpq_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // command side checks
   assign accept     = in_valid && in_ready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign new_idx    = count_ff[IDX_W-1:0];
   assign new_parent = (new_idx - 1'b1) >> 1;

   // sift-up compare: parent is in read port a
   assign hole_parent = (hole_ff - 1'b1) >> 1;
   assign hole_grand  = (hole_parent - 1'b1) >> 1;
   assign climb       = (hole_ff != '0) && (rd_data_a.prio < item_ff.prio);

   // sift-down compare: left child on port a, right child on port b
   assign count_wide  = CHILD_W'(count_ff);
   assign l_idx       = (CHILD_W'(hole_ff) << 1) + CHILD_W'(1);
   assign r_idx       = (CHILD_W'(hole_ff) << 1) + CHILD_W'(2);
   assign take_l      = (l_idx < count_wide) && (rd_data_a.prio > item_ff.prio);
   assign best_prio   = take_l ? rd_data_a.prio : item_ff.prio;
   assign take_r      = (r_idx < count_wide) && (rd_data_b.prio > best_prio);
   assign descend     = take_l || take_r;
   assign child_idx   = take_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
   assign child_entry = take_r ? rd_data_b : rd_data_a;
   assign child_l     = IDX_W'({child_idx, 1'b1});
   assign child_r     = IDX_W'({child_idx, 1'b0} + (IDX_W + 1)'(2));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (in_cmd == CMD_INSERT) begin
                  state_in = full ? S_DONE : S_SIFT_UP;
               end else begin
                  state_in = empty ? S_DONE : S_LOAD;
               end
            end
         end
         S_SIFT_UP: begin
            if (!climb) begin
               state_in = S_DONE;
            end
         end
         S_LOAD: begin
            state_in = empty ? S_DONE : S_SIFT_DOWN;
         end
         S_SIFT_DOWN: begin
            if (!descend) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, ram controls and handshake outputs
   always_comb begin
      in_ready  = 1'b0;
      out_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = hole_ff;
      wr_data   = item_ff;
      rd_addr_a = hole_parent;
      rd_addr_b = '0;
      count_in  = count_ff;
      hole_in   = hole_ff;
      item_in   = item_ff;
      result_in = result_ff;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_cmd == CMD_INSERT) begin
               rd_addr_a = new_parent;
               if (full) begin
                  result_in = '{status: ST_FULL, count: count_ff, entry: '0};
               end else begin
                  item_in   = in_entry;
                  hole_in   = new_idx;
                  count_in  = count_ff + 1'b1;
                  result_in = '{status: ST_INSERTED, count: count_ff + 1'b1, entry: '0};
               end
            end else begin
               rd_addr_a = '0;
               rd_addr_b = IDX_W'(count_ff - 1'b1);
               if (empty) begin
                  result_in = '{status: ST_EMPTY, count: count_ff, entry: '0};
               end else begin
                  count_in  = count_ff - 1'b1;
                  result_in = '{status: ST_EXTRACTED, count: count_ff - 1'b1, entry: '0};
               end
            end
            // hold everything unless a transaction is taken
            if (!accept) begin
               count_in  = count_ff;
               hole_in   = hole_ff;
               item_in   = item_ff;
               result_in = result_ff;
            end
         end
         S_SIFT_UP: begin
            wr_en     = 1'b1;
            rd_addr_a = hole_grand;
            if (climb) begin
               wr_data = rd_data_a;
               hole_in = hole_parent;
            end
         end
         S_LOAD: begin
            // root goes out, last entry starts at the root
            result_in.entry = rd_data_a;
            item_in         = rd_data_b;
            hole_in         = '0;
            rd_addr_a       = IDX_W'(1);
            rd_addr_b       = IDX_W'(2);
         end
         S_SIFT_DOWN: begin
            wr_en     = 1'b1;
            rd_addr_a = child_l;
            rd_addr_b = child_r;
            if (descend) begin
               wr_data = child_entry;
               hole_in = child_idx;
            end
         end
         S_DONE: begin
            out_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hole_ff   <= hole_in;
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign out_item = result_ff;

endmodule

[rtl/max_heap_priority_queue.sv]
// top level of the max-heap priority queue with result output register
`timescale 1ns / 1ps

// channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tdata: priority, patient id, kind; tuser: command
// rsp     | out | rsp_tvalid/tready  | tdata: priority, patient id, kind, count; tuser: status
//
// insert: the new entry climbs one level per sift step, up to log2(DEPTH) levels;
// extract: a load step, then the moved entry sinks one level per sift step (no sift
// step when it empties the heap); errors go straight to the finish step.
// each sift level costs one cycle: the next ram read overlaps the write-back.
// reset clears the entry count and all handshake state; ram contents stay as they are.
// a result waiting on rsp holds the sequencer in its finish step; req stalls until idle.

module max_heap_priority_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] priority_req, [23:8] patient_id, [27:24] case_kind, rest zero
   input  logic [mhpq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] command
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_priority, [23:8] out_patient_id, [27:24] out_case_kind,
   // [34:28] entry_count, rest zero
   output logic [mhpq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [1:0]                        rsp_tuser
);
   import mhpq_pkg::*;

   logic         ctrl_valid, slot_free;
   rsp_item_type ctrl_item;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (cmd_type'(req_tuser)),
      .in_entry  (entry_type'(req_tdata[ENTRY_W-1:0])),
      .out_valid (ctrl_valid),
      .out_ready (slot_free),
      .out_item  (ctrl_item)
   );

   // output register loads when empty or being drained
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (ctrl_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = ctrl_item;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   // pack the result transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_item_ff.status;
   assign rsp_tdata  = RSP_DATA_W'({rsp_item_ff.count, rsp_item_ff.entry});

endmodule
